[rtl/core/fmq_pkg.sv]
// Package: breakpoint geometry, quality table and shared types for the FM quality block.
package fmq_pkg;

  localparam int unsigned NFS = 16;
  localparam int unsigned NNS = 5;
  localparam int unsigned NMP = 5;
  localparam int unsigned QDEPTH = 2;

  localparam logic [0:0] REG_OFFSET_MODE = 1'b0;
  localparam logic [0:0] REG_OFFSET_THR  = 1'b1;

  // One classified beat travelling from front to back.
  typedef struct packed {
    logic       gate;
    logic [3:0] f1;
    logic [2:0] n1;
    logic [2:0] m1;
    logic [7:0] pf2;
    logic [7:0] pn2;
    logic [7:0] pm2;
  } fmq_job_t;

  // Quality table, flattened [n][m][f], 80 entries per noise row.
  localparam logic [6:0] QTAB [0:NNS*NMP*NFS-1] = '{
    7'd30,7'd35,7'd45,7'd55,7'd65,7'd75,7'd80,7'd80,
    7'd85,7'd90,7'd90,7'd95,7'd100,7'd100,7'd100,7'd100,
    7'd25,7'd30,7'd40,7'd50,7'd60,7'd70,7'd75,7'd75,
    7'd80,7'd85,7'd85,7'd90,7'd95,7'd95,7'd95,7'd95,
    7'd15,7'd20,7'd30,7'd40,7'd50,7'd60,7'd65,7'd65,
    7'd70,7'd75,7'd75,7'd80,7'd85,7'd85,7'd85,7'd85,
    7'd10,7'd15,7'd25,7'd35,7'd42,7'd50,7'd55,7'd55,
    7'd60,7'd65,7'd65,7'd70,7'd75,7'd75,7'd75,7'd75,
    7'd10,7'd15,7'd25,7'd35,7'd40,7'd45,7'd50,7'd50,
    7'd55,7'd60,7'd60,7'd65,7'd70,7'd70,7'd70,7'd70,
    7'd25,7'd30,7'd40,7'd50,7'd60,7'd70,7'd75,7'd77,
    7'd82,7'd85,7'd87,7'd92,7'd95,7'd95,7'd95,7'd95,
    7'd22,7'd27,7'd37,7'd46,7'd55,7'd63,7'd68,7'd71,
    7'd75,7'd78,7'd81,7'd86,7'd90,7'd91,7'd92,7'd92,
    7'd17,7'd21,7'd30,7'd37,7'd45,7'd52,7'd57,7'd60,
    7'd62,7'd67,7'd70,7'd75,7'd80,7'd82,7'd85,7'd85,
    7'd12,7'd15,7'd22,7'd30,7'd36,7'd42,7'd47,7'd50,
    7'd52,7'd57,7'd60,7'd65,7'd70,7'd72,7'd75,7'd75,
    7'd10,7'd12,7'd20,7'd27,7'd32,7'd37,7'd42,7'd45,
    7'd47,7'd52,7'd55,7'd60,7'd65,7'd67,7'd70,7'd70,
    7'd15,7'd20,7'd27,7'd32,7'd40,7'd47,7'd52,7'd57,
    7'd60,7'd62,7'd67,7'd72,7'd75,7'd77,7'd82,7'd85,
    7'd15,7'd20,7'd27,7'd31,7'd36,7'd41,7'd46,7'd51,
    7'd52,7'd56,7'd61,7'd66,7'd70,7'd73,7'd80,7'd82,
    7'd15,7'd17,7'd22,7'd25,7'd28,7'd32,7'd36,7'd40,
    7'd40,7'd45,7'd50,7'd55,7'd60,7'd65,7'd72,7'd75,
    7'd12,7'd12,7'd15,7'd17,7'd21,7'd26,7'd30,7'd32,
    7'd32,7'd36,7'd41,7'd46,7'd50,7'd55,7'd62,7'd65,
    7'd10,7'd10,7'd12,7'd15,7'd17,7'd22,7'd27,7'd30,
    7'd30,7'd32,7'd37,7'd42,7'd45,7'd50,7'd57,7'd60,
    7'd10,7'd12,7'd15,7'd15,7'd20,7'd25,7'd30,7'd35,
    7'd35,7'd40,7'd45,7'd45,7'd45,7'd45,7'd45,7'd45,
    7'd10,7'd12,7'd15,7'd15,7'd18,7'd22,7'd26,7'd30,
    7'd30,7'd35,7'd40,7'd45,7'd45,7'd45,7'd45,7'd45,
    7'd10,7'd11,7'd12,7'd12,7'd15,7'd18,7'd21,7'd22,
    7'd22,7'd26,7'd30,7'd35,7'd40,7'd45,7'd45,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd11,7'd15,7'd17,7'd18,
    7'd20,7'd21,7'd23,7'd27,7'd30,7'd35,7'd45,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd12,7'd15,7'd17,
    7'd20,7'd20,7'd22,7'd25,7'd25,7'd30,7'd40,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd15,7'd20,7'd25,7'd30,
    7'd30,7'd35,7'd40,7'd45,7'd45,7'd45,7'd45,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd15,7'd20,7'd22,7'd25,
    7'd25,7'd30,7'd35,7'd40,7'd45,7'd45,7'd45,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd12,7'd17,7'd20,7'd20,
    7'd20,7'd22,7'd25,7'd30,7'd35,7'd40,7'd45,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd12,7'd15,7'd17,
    7'd20,7'd20,7'd20,7'd22,7'd25,7'd30,7'd40,7'd45,
    7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd10,7'd15,
    7'd20,7'd20,7'd20,7'd20,7'd20,7'd25,7'd35,7'd40};

  // Flat table address of corner [n][m][f].
  function automatic logic [8:0] qidx(input logic [2:0] n, input logic [2:0] m,
                                      input logic [3:0] f);
    return {6'd0, n} * 9'd80 + {6'd0, m} * 9'd16 + {5'd0, f};
  endfunction

endpackage

[rtl/core/fm_quality_trilinear_interp.sv]
// Top level of the FM quality block.
// Path: an accepted beat is registered in the queue, then runs 15 back-end steps (0..14);
//   a gated beat skips the steps and its result is registered when the back end takes it.
// Throughput: fourteen products share one 14x8 multiplier; the back end takes a new beat
//   once the last result is taken, so gated beats go one per cycle with out_ready high.
// The two-entry queue lets the front take two more beats while the back end is busy.
// Reset (rst_n low, synchronous): offset mode on, threshold 20, queue and back end empty.
module fm_quality_trilinear_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_field_strength,
  input  logic [7:0]        in_noise_level,
  input  logic [7:0]        in_multipath_level,
  input  logic [7:0]        in_freq_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_quality,
  output logic [6:0]        out_quality_fs_only,
  output logic [6:0]        out_quality_no_multipath,
  output logic              out_gated,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);
  import fmq_pkg::*;

  logic       mode_r;
  logic [7:0] thr_r;
  fmq_job_t   job_f, job_b;
  logic       job_f_valid, job_f_ready, job_b_valid, job_b_ready;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1; thr_r <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OFFSET_MODE) mode_r <= cfg_data[0];
      else if (cfg_index == REG_OFFSET_THR) thr_r <= cfg_data;
    end
  end

  // front: clamp, cell search and weights in the accepting cycle
  fmq_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_field_strength  (in_field_strength),
    .in_noise_level     (in_noise_level),
    .in_multipath_level (in_multipath_level),
    .in_freq_offset     (in_freq_offset),
    .mode               (mode_r),
    .thr                (thr_r),
    .job_valid          (job_f_valid),
    .job_ready          (job_f_ready),
    .job                (job_f)
  );

  fmq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (job_f_valid),
    .wr_ready (job_f_ready),
    .wr_job   (job_f),
    .rd_valid (job_b_valid),
    .rd_ready (job_b_ready),
    .rd_job   (job_b)
  );

  // back: multi-cycle interpolation, result held until taken
  fmq_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .job_valid                (job_b_valid),
    .job_ready                (job_b_ready),
    .job                      (job_b),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_quality              (out_quality),
    .out_quality_fs_only      (out_quality_fs_only),
    .out_quality_no_multipath (out_quality_no_multipath),
    .out_gated                (out_gated)
  );

endmodule

[rtl/core/fmq_front.sv]
// Front end: clamps readings, finds breakpoint cells and weights, pushes a job.
module fmq_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_field_strength,
  input  logic [7:0]        in_noise_level,
  input  logic [7:0]        in_multipath_level,
  input  logic [7:0]        in_freq_offset,
  input  logic              mode,
  input  logic [7:0]        thr,
  output logic              job_valid,
  input  logic              job_ready,
  output fmq_pkg::fmq_job_t job
);
  import fmq_pkg::*;

  logic [6:0]  fs, ns, mp;
  logic [8:0]  nsum;
  logic [6:0]  nsat;
  logic [15:0] fdiv;
  logic [3:0]  f1;
  logic [6:0]  flo;
  logic [2:0]  n1, m1;
  logic [6:0]  nlo, mlo;
  logic [6:0]  fdel, ndel, mdel;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;

  // 128*d/5 truncated, d = 0..5
  function automatic logic [7:0] w_fifth(input logic [3:0] d);
    logic [7:0] w;
    case (d)
      4'd0:    w = 8'd0;
      4'd1:    w = 8'd25;
      4'd2:    w = 8'd51;
      4'd3:    w = 8'd76;
      4'd4:    w = 8'd102;
      default: w = 8'd128;
    endcase
    return w;
  endfunction

  // 128*d/10 truncated, d = 0..10
  function automatic logic [7:0] w_tenth(input logic [3:0] d);
    logic [7:0] w;
    case (d)
      4'd0:    w = 8'd0;
      4'd1:    w = 8'd12;
      4'd2:    w = 8'd25;
      4'd3:    w = 8'd38;
      4'd4:    w = 8'd51;
      4'd5:    w = 8'd64;
      4'd6:    w = 8'd76;
      4'd7:    w = 8'd89;
      4'd8:    w = 8'd102;
      4'd9:    w = 8'd115;
      default: w = 8'd128;
    endcase
    return w;
  endfunction

  // 128*d/7 truncated, d = 0..7
  function automatic logic [7:0] w_seventh(input logic [3:0] d);
    logic [7:0] w;
    case (d)
      4'd0:    w = 8'd0;
      4'd1:    w = 8'd18;
      4'd2:    w = 8'd36;
      4'd3:    w = 8'd54;
      4'd4:    w = 8'd73;
      4'd5:    w = 8'd91;
      4'd6:    w = 8'd109;
      default: w = 8'd128;
    endcase
    return w;
  endfunction

  always_comb begin
    if (in_field_strength[7]) fs = 7'd0;
    else if (in_field_strength > 8'sd75) fs = 7'd75;
    else fs = in_field_strength[6:0];
    nsum = {1'b0, in_noise_level} + {1'b0, in_freq_offset};
    if (mode) nsat = (nsum > 9'd127) ? 7'd127 : nsum[6:0];
    else nsat = (in_noise_level > 8'd35) ? 7'd35 : in_noise_level[6:0];
    ns = (nsat > 7'd35) ? 7'd35 : nsat;
    mp = (in_multipath_level > 8'd25) ? 7'd25 : in_multipath_level[6:0];
    // fs cells of 5: lower index = ceil(fs/5)-1, floor at 0; x*205>>10 is x/5 here
    fdiv = 16'(fs - 7'd1) * 16'd205;
    f1 = (fs == 7'd0) ? 4'd0 : fdiv[13:10];
    flo = 7'({3'd0, f1} * 7'd5);
    if (ns <= 7'd5) begin n1 = 3'd0; nlo = 7'd0; end
    else if (ns <= 7'd15) begin n1 = 3'd1; nlo = 7'd5; end
    else if (ns <= 7'd25) begin n1 = 3'd2; nlo = 7'd15; end
    else begin n1 = 3'd3; nlo = 7'd25; end
    if (mp <= 7'd8) begin m1 = 3'd0; mlo = 7'd0; end
    else if (mp <= 7'd13) begin m1 = 3'd1; mlo = 7'd8; end
    else if (mp <= 7'd18) begin m1 = 3'd2; mlo = 7'd13; end
    else begin m1 = 3'd3; mlo = 7'd18; end
    fdel = fs - flo;
    ndel = ns - nlo;
    mdel = mp - mlo;
    job.gate = !mode && (in_freq_offset >= thr);
    job.f1 = f1;
    job.n1 = n1;
    job.m1 = m1;
    job.pf2 = w_fifth(fdel[3:0]);
    job.pn2 = (n1 == 3'd0) ? w_fifth(ndel[3:0]) : w_tenth(ndel[3:0]);
    case (m1)
      3'd0:    job.pm2 = {mdel[3:0], 4'd0};
      3'd3:    job.pm2 = w_seventh(mdel[3:0]);
      default: job.pm2 = w_fifth(mdel[3:0]);
    endcase
  end

endmodule

[rtl/core/fmq_queue.sv]
// Two-entry job queue between front and back.
module fmq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  fmq_pkg::fmq_job_t wr_job,
  output logic              rd_valid,
  input  logic              rd_ready,
  output fmq_pkg::fmq_job_t rd_job
);
  import fmq_pkg::*;

  fmq_job_t   mem_r [0:QDEPTH-1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/fmq_back.sv]
// Back end: one shared multiplier steps through the fourteen products of a job.
module fmq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  fmq_pkg::fmq_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_quality,
  output logic [6:0]        out_quality_fs_only,
  output logic [6:0]        out_quality_no_multipath,
  output logic              out_gated
);
  import fmq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  state_t      st_r;
  logic [3:0]  step_r;
  fmq_job_t    j_r;
  logic [6:0]  tq_r;
  logic [20:0] acc_r;
  logic [13:0] qab_r, qcd_r, qef_r, qgh_r, qabef_r, qcdgh_r;
  logic        valid_r, gated_r;
  logic [6:0]  q_r, qfs_r, qnm_r;
  logic [2:0]  n, m;
  logic [3:0]  f;
  logic [13:0] mul_a;
  logic [7:0]  mul_b;
  logic [21:0] prod;
  logic [20:0] acc_nxt;
  logic [6:0]  qrnd;
  logic        take;

  // a new job may follow in the cycle its predecessor's result is taken
  assign job_ready = (st_r == S_IDLE) || ((st_r == S_OUT) && out_ready);
  assign take      = job_valid && job_ready;

  assign out_valid                = valid_r;
  assign out_quality              = q_r;
  assign out_quality_fs_only      = qfs_r;
  assign out_quality_no_multipath = qnm_r;
  assign out_gated                = gated_r;

  // table read for corner step (0..7) is registered; its product runs a step later.
  // steps 1..8 corner products, 9..12 noise, 13..14 multipath; odd steps start a sum
  always_comb begin
    n = j_r.n1 + {2'd0, step_r[2]};
    m = j_r.m1 + {2'd0, step_r[1]};
    f = j_r.f1 + {3'd0, step_r[0]};
    mul_a = {7'd0, tq_r};
    mul_b = step_r[0] ? 8'(9'd128 - {1'b0, j_r.pf2}) : j_r.pf2;
    case (step_r)
      4'd9:  begin mul_a = qab_r;   mul_b = 8'(9'd128 - {1'b0, j_r.pn2}); end
      4'd10: begin mul_a = qef_r;   mul_b = j_r.pn2; end
      4'd11: begin mul_a = qcd_r;   mul_b = 8'(9'd128 - {1'b0, j_r.pn2}); end
      4'd12: begin mul_a = qgh_r;   mul_b = j_r.pn2; end
      4'd13: begin mul_a = qabef_r; mul_b = 8'(9'd128 - {1'b0, j_r.pm2}); end
      4'd14: begin mul_a = qcdgh_r; mul_b = j_r.pm2; end
      default: ;
    endcase
    prod = {8'd0, mul_a} * {14'd0, mul_b};
    acc_nxt = (step_r[0] ? 21'd0 : acc_r) + prod[20:0];
    // round to nearest, half up
    qrnd = acc_nxt[20:14] + {6'd0, (acc_nxt[13:0] >= 14'h2000)};
  end

  always_ff @(posedge clk) begin
    tq_r <= QTAB[qidx(n, m, f)];
    if (!rst_n) begin
      st_r <= S_IDLE; step_r <= 4'd0; valid_r <= 1'b0;
    end else if (take) begin
      j_r <= job; step_r <= 4'd0;
      if (job.gate) begin
        q_r <= 7'd10; qfs_r <= 7'd0; qnm_r <= 7'd0; gated_r <= 1'b1;
        valid_r <= 1'b1; st_r <= S_OUT;
      end else begin
        valid_r <= 1'b0; st_r <= S_RUN;
      end
    end else begin
      case (st_r)
        S_RUN: begin
          acc_r <= acc_nxt;
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd2:  qab_r <= acc_nxt[13:0];
            4'd4:  qcd_r <= acc_nxt[13:0];
            4'd6:  qef_r <= acc_nxt[13:0];
            4'd8:  qgh_r <= acc_nxt[13:0];
            4'd10: qabef_r <= acc_nxt[20:7];
            4'd12: qcdgh_r <= acc_nxt[20:7];
            4'd14: begin
              q_r <= qrnd; qfs_r <= qab_r[13:7]; qnm_r <= qabef_r[13:7];
              gated_r <= 1'b0; valid_r <= 1'b1; st_r <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: if (out_ready) begin
          valid_r <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_fm_quality_trilinear_interp.sv]
// Testbench: self-checking random and directed test of the FM quality interpolator.
module tb_fm_quality_trilinear_interp;
  timeunit 1ns;
  timeprecision 1ps;

  import fmq_pkg::*;

  // One set of tuner readings
  typedef struct {
    logic signed [7:0] fs;
    logic [7:0]        noise;
    logic [7:0]        mpath;
    logic [7:0]        ofs;
  } reading_t;

  // One expected quality beat
  typedef struct {
    logic [6:0] q;
    logic [6:0] q_fs;
    logic [6:0] q_nm;
    logic       gated;
  } quality_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [7:0] in_field_strength = '0;
  logic [7:0]        in_noise_level = '0;
  logic [7:0]        in_multipath_level = '0;
  logic [7:0]        in_freq_offset = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [6:0]        out_quality;
  logic [6:0]        out_quality_fs_only;
  logic [6:0]        out_quality_no_multipath;
  logic              out_gated;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_OFFSET_MODE;
  logic [7:0]        cfg_data = '0;

  fm_quality_trilinear_interp uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the two registers
  logic       mode_add;
  logic [7:0] gate_thr;

  reading_t pending_readings[$];
  quality_t expected_quality[$];

  int unsigned send_idle_pct = 12; // sender idle chance, percent
  int unsigned recv_idle_pct = 48; // receiver idle chance, percent
  bit          hold_recv = 1'b0;   // long receiver hold-off in progress
  bit          hold_go = 1'b0;     // starts the hold-off
  int          n_mismatch = 0;
  int          n_beats = 0;
  int          n_gated = 0;
  bit          done = 1'b0;

  // Breakpoint tables, same geometry as the block
  function automatic int unsigned fs_point(int unsigned i);
    return i * 5;
  endfunction

  function automatic int unsigned ns_point(int unsigned i);
    int unsigned p[5] = '{0, 5, 15, 25, 35};
    return p[i];
  endfunction

  function automatic int unsigned mp_point(int unsigned i);
    int unsigned p[5] = '{0, 8, 13, 18, 25};
    return p[i];
  endfunction

  // Quality table, indexed [noise][multipath][field strength]
  function automatic int unsigned qual_table(int unsigned n, int unsigned m, int unsigned f);
    byte unsigned t[5][5][16] = '{
      '{'{30,35,45,55,65,75,80,80,85,90,90,95,100,100,100,100},
        '{25,30,40,50,60,70,75,75,80,85,85,90,95,95,95,95},
        '{15,20,30,40,50,60,65,65,70,75,75,80,85,85,85,85},
        '{10,15,25,35,42,50,55,55,60,65,65,70,75,75,75,75},
        '{10,15,25,35,40,45,50,50,55,60,60,65,70,70,70,70}},
      '{'{25,30,40,50,60,70,75,77,82,85,87,92,95,95,95,95},
        '{22,27,37,46,55,63,68,71,75,78,81,86,90,91,92,92},
        '{17,21,30,37,45,52,57,60,62,67,70,75,80,82,85,85},
        '{12,15,22,30,36,42,47,50,52,57,60,65,70,72,75,75},
        '{10,12,20,27,32,37,42,45,47,52,55,60,65,67,70,70}},
      '{'{15,20,27,32,40,47,52,57,60,62,67,72,75,77,82,85},
        '{15,20,27,31,36,41,46,51,52,56,61,66,70,73,80,82},
        '{15,17,22,25,28,32,36,40,40,45,50,55,60,65,72,75},
        '{12,12,15,17,21,26,30,32,32,36,41,46,50,55,62,65},
        '{10,10,12,15,17,22,27,30,30,32,37,42,45,50,57,60}},
      '{'{10,12,15,15,20,25,30,35,35,40,45,45,45,45,45,45},
        '{10,12,15,15,18,22,26,30,30,35,40,45,45,45,45,45},
        '{10,11,12,12,15,18,21,22,22,26,30,35,40,45,45,45},
        '{10,10,10,10,11,15,17,18,20,21,23,27,30,35,45,45},
        '{10,10,10,10,10,12,15,17,20,20,22,25,25,30,40,45}},
      '{'{10,10,10,10,15,20,25,30,30,35,40,45,45,45,45,45},
        '{10,10,10,10,15,20,22,25,25,30,35,40,45,45,45,45},
        '{10,10,10,10,12,17,20,20,20,22,25,30,35,40,45,45},
        '{10,10,10,10,10,12,15,17,20,20,20,22,25,30,40,45},
        '{10,10,10,10,10,10,10,15,20,20,20,20,20,25,35,40}}};
    return t[n][m][f];
  endfunction

  // Predict one quality beat from one reading and the current registers
  function automatic quality_t predict_quality(reading_t r);
    quality_t    e;
    int unsigned fs, ns, mp, f2, n2, m2, pf2, pn2, pm2, pf1, pn1, pm1;
    int unsigned qab, qcd, qef, qgh, qabef, qcdgh, acc;
    fs = r.fs < 0 ? 0 : (r.fs > 75 ? 75 : int'(r.fs));
    ns = r.noise;
    mp = r.mpath;
    if (mode_add) begin
      ns = ns + r.ofs;
      if (ns > 127) ns = 127;
    end else if (r.ofs >= gate_thr) begin
      e.q = 7'd10; e.q_fs = '0; e.q_nm = '0; e.gated = 1'b1;
      return e;
    end
    if (ns > 35) ns = 35;
    if (mp > 25) mp = 25;
    // upper enclosing breakpoint on each axis
    f2 = 1; while (f2 < 15 && fs_point(f2) < fs) f2++;
    n2 = 1; while (n2 < 4 && ns_point(n2) < ns) n2++;
    m2 = 1; while (m2 < 4 && mp_point(m2) < mp) m2++;
    pf2 = ((fs - fs_point(f2-1)) << 7) / (fs_point(f2) - fs_point(f2-1));
    pn2 = ((ns - ns_point(n2-1)) << 7) / (ns_point(n2) - ns_point(n2-1));
    pm2 = ((mp - mp_point(m2-1)) << 7) / (mp_point(m2) - mp_point(m2-1));
    pf1 = 128 - pf2; pn1 = 128 - pn2; pm1 = 128 - pm2;
    qab = qual_table(n2-1, m2-1, f2-1) * pf1 + qual_table(n2-1, m2-1, f2) * pf2;
    qcd = qual_table(n2-1, m2, f2-1) * pf1 + qual_table(n2-1, m2, f2) * pf2;
    qef = qual_table(n2, m2-1, f2-1) * pf1 + qual_table(n2, m2-1, f2) * pf2;
    qgh = qual_table(n2, m2, f2-1) * pf1 + qual_table(n2, m2, f2) * pf2;
    qabef = (qab * pn1 + qef * pn2) >> 7;
    qcdgh = (qcd * pn1 + qgh * pn2) >> 7;
    acc = qabef * pm1 + qcdgh * pm2;
    e.q = 7'((acc >> 14) + ((acc & 32'h3fff) >= 32'h2000 ? 1 : 0));
    e.q_fs = 7'(qab >> 7);
    e.q_nm = 7'(qabef >> 7);
    e.gated = 1'b0;
    return e;
  endfunction

  // Driver: offers queued readings, predicting each one as it is accepted
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_quality.push_back(predict_quality('{in_field_strength, in_noise_level,
                                                    in_multipath_level, in_freq_offset}));
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        reading_t r;
        r = pending_readings.pop_front();
        in_valid <= 1'b1;
        in_field_strength <= r.fs;
        in_noise_level <= r.noise;
        in_multipath_level <= r.mpath;
        in_freq_offset <= r.ofs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      quality_t e;
      n_beats++;
      if (expected_quality.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result beat q=%0d", out_quality);
      end else begin
        e = expected_quality.pop_front();
        if (e.gated) n_gated++;
        if (out_quality !== e.q || out_quality_fs_only !== e.q_fs ||
            out_quality_no_multipath !== e.q_nm || out_gated !== e.gated) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp q=%0d fs=%0d nm=%0d g=%0b got q=%0d fs=%0d nm=%0d g=%0b",
                     e.q, e.q_fs, e.q_nm, e.gated, out_quality, out_quality_fs_only,
                     out_quality_no_multipath, out_gated);
        end
      end
    end
    out_ready <= rst_n && !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Receiver hold-off, counted in clock cycles
  initial begin
    wait (hold_go);
    hold_recv = 1'b1;
    repeat (300) @(posedge clk);
    hold_recv = 1'b0;
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OFFSET_MODE) mode_add = val[0];
    else gate_thr = val;
  endtask

  // Block must be idle before a register write; sampled on the falling edge
  task automatic drain();
    while (pending_readings.size() != 0 || in_valid || expected_quality.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_reading(input int f, input int n, input int m, input int o);
    pending_readings.push_back('{8'(f), 8'(n), 8'(m), 8'(o)});
  endtask

  // Random reading, mostly inside the breakpoint ranges
  task automatic queue_random(input int count);
    repeat (count) begin
      if ($urandom_range(3) != 0)
        queue_reading($urandom_range(75), $urandom_range(40), $urandom_range(30),
                      $urandom_range(40));
      else
        queue_reading($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    mode_add = 1'b1;
    gate_thr = 8'd20;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, offset mode at reset value: extremes, breakpoints, saturation
    queue_reading(-128, 0, 0, 0);
    queue_reading(127, 255, 255, 255);
    queue_reading(75, 35, 25, 0);
    queue_reading(0, 0, 0, 0);
    queue_reading(-1, 5, 8, 0);
    queue_reading(74, 34, 24, 0);
    queue_reading(3, 100, 13, 100);
    queue_reading(37, 12, 18, 3);
    queue_reading(76, 36, 26, 0);
    queue_reading(52, 20, 10, 255);
    drain();

    // gating mode, offsets either side of the threshold
    write_reg(REG_OFFSET_MODE, 8'd0);
    write_reg(REG_OFFSET_THR, 8'd20);
    queue_reading(40, 10, 10, 19);
    queue_reading(40, 10, 10, 20);
    queue_reading(-50, 255, 255, 255);
    queue_reading(63, 0, 0, 0);
    drain();
    write_reg(REG_OFFSET_THR, 8'd0);
    queue_reading(40, 10, 10, 0);
    drain();
    write_reg(REG_OFFSET_THR, 8'd255);
    queue_reading(40, 10, 10, 254);
    queue_reading(40, 10, 10, 255);
    drain();

    // random: sender idles lightly, receiver heavily
    send_idle_pct = 12; recv_idle_pct = 48;
    write_reg(REG_OFFSET_THR, 8'($urandom_range(10, 40)));
    queue_random(150);
    drain();

    // offset mode again, idling the other way round
    send_idle_pct = 48; recv_idle_pct = 12;
    write_reg(REG_OFFSET_MODE, 8'hff);
    queue_random(150);
    drain();

    // no idling; long receiver hold-off so the block backs up
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_OFFSET_MODE, 8'd0);
    write_reg(REG_OFFSET_THR, 8'($urandom));
    hold_go = 1'b1;
    queue_random(180);
    drain();

    $display("covered %0d quality beats (%0d gated) over both offset modes", n_beats, n_gated);
    $display("thresholds 0, 20, 255 and random, with sender and receiver stalls");
    if (n_mismatch == 0 && expected_quality.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
